// ===== hdl/dsp_pkg.sv =====
`timescale 1ns / 1ps
package dsp_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int MAX_EDGES  = 4096;
    localparam int EIDX_W     = $clog2(MAX_EDGES);
    localparam int EDGE_W     = $clog2(MAX_EDGES + 1);
    localparam int HEAP_DEPTH = MAX_EDGES + 1;
    localparam int HIDX_W     = $clog2(HEAP_DEPTH + 1);
    localparam int DIST_W     = 48;
    localparam int WEIGHT_W   = 32;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [NODE_W-1:0]   edge_from;
        logic [NODE_W-1:0]   edge_to;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              reached;
    } t_out_item;

    typedef struct packed {
        logic [NODE_W-1:0]   to;
        logic [EDGE_W-1:0]   next;
        logic [WEIGHT_W-1:0] weight;
    } t_edge_rec;

    typedef struct packed {
        logic [DIST_W-1:0] cost;
        logic [NODE_W-1:0] node;
    } t_heap_rec;

    typedef struct packed {
        logic known;
        logic visited;
    } t_flags;

    typedef enum logic [4:0] {
        S_CLR_HEAD, S_IDLE, S_ADD, S_RUN_CLR, S_RUN_INIT, S_LOOP,
        S_POP_TOP, S_POP_LAST, S_POP_CHK, S_POP_C1, S_POP_C2, S_POP_CMP,
        S_VIS_RD, S_VIS_CHK, S_E_CHK, S_E_RD, S_E_REL, S_PU_CHK, S_PU_CMP,
        S_FIN_RD, S_RESULT
    } t_state;

    typedef enum logic [4:0] {
        OP_CLR_HEAD, OP_IDLE, OP_ADD, OP_RUN_CLR, OP_RUN_INIT, OP_LOOP,
        OP_POP_TOP, OP_POP_LAST, OP_POP_CHK, OP_POP_C1, OP_POP_C2, OP_POP_CMP,
        OP_VIS_RD, OP_VIS_CHK, OP_E_CHK, OP_E_RD, OP_E_REL, OP_PU_CHK, OP_PU_CMP,
        OP_FIN_RD, OP_RESULT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic take;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic heap_empty;
        logic pop_single;
        logic down_end;
        logic has_c1;
        logic down_stop;
        logic visited;
        logic edge_more;
        logic relax;
        logic heap_full;
        logic up_root;
        logic up_stop;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/dsp_ctrl.sv =====
`timescale 1ns / 1ps
module dsp_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [dsp_pkg::ACT_W-1:0] i_action,
    input  dsp_pkg::t_status         i_status,
    output dsp_pkg::t_cmd            o_cmd
);
    import dsp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_take;

    assign w_take = (r_state == S_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_HEAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR_HEAD: begin
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_take) begin
                    unique case (i_action)
                        ACT_ADD:   n_state = S_ADD;
                        ACT_RUN:   n_state = S_RUN_CLR;
                        ACT_CLEAR: n_state = S_CLR_HEAD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD:      n_state = S_IDLE;
            S_RUN_CLR: begin
                if (i_status.clr_last) n_state = S_RUN_INIT;
            end
            S_RUN_INIT: n_state = S_LOOP;
            S_LOOP:     n_state = i_status.heap_empty ? S_FIN_RD : S_POP_TOP;
            S_POP_TOP:  n_state = i_status.pop_single ? S_VIS_RD : S_POP_LAST;
            S_POP_LAST: n_state = S_POP_CHK;
            S_POP_CHK:  n_state = i_status.down_end ? S_VIS_RD : S_POP_C1;
            S_POP_C1:   n_state = i_status.has_c1 ? S_POP_C2 : S_POP_CMP;
            S_POP_C2:   n_state = S_POP_CMP;
            S_POP_CMP:  n_state = i_status.down_stop ? S_VIS_RD : S_POP_CHK;
            S_VIS_RD:   n_state = S_VIS_CHK;
            S_VIS_CHK:  n_state = i_status.visited ? S_LOOP : S_E_CHK;
            S_E_CHK:    n_state = i_status.edge_more ? S_E_RD : S_LOOP;
            S_E_RD:     n_state = S_E_REL;
            S_E_REL: begin
                if (i_status.relax && !i_status.heap_full) n_state = S_PU_CHK;
                else n_state = S_E_CHK;
            end
            S_PU_CHK:   n_state = i_status.up_root ? S_E_CHK : S_PU_CMP;
            S_PU_CMP:   n_state = i_status.up_stop ? S_E_CHK : S_PU_CHK;
            S_FIN_RD:   n_state = S_RESULT;
            S_RESULT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.take = w_take;
        o_cmd.load = (r_state == S_RESULT) && i_status.out_free;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_CLR_HEAD: o_cmd.op = OP_CLR_HEAD;
            S_IDLE:     o_cmd.op = OP_IDLE;
            S_ADD:      o_cmd.op = OP_ADD;
            S_RUN_CLR:  o_cmd.op = OP_RUN_CLR;
            S_RUN_INIT: o_cmd.op = OP_RUN_INIT;
            S_LOOP:     o_cmd.op = OP_LOOP;
            S_POP_TOP:  o_cmd.op = OP_POP_TOP;
            S_POP_LAST: o_cmd.op = OP_POP_LAST;
            S_POP_CHK:  o_cmd.op = OP_POP_CHK;
            S_POP_C1:   o_cmd.op = OP_POP_C1;
            S_POP_C2:   o_cmd.op = OP_POP_C2;
            S_POP_CMP:  o_cmd.op = OP_POP_CMP;
            S_VIS_RD:   o_cmd.op = OP_VIS_RD;
            S_VIS_CHK:  o_cmd.op = OP_VIS_CHK;
            S_E_CHK:    o_cmd.op = OP_E_CHK;
            S_E_RD:     o_cmd.op = OP_E_RD;
            S_E_REL:    o_cmd.op = OP_E_REL;
            S_PU_CHK:   o_cmd.op = OP_PU_CHK;
            S_PU_CMP:   o_cmd.op = OP_PU_CMP;
            S_FIN_RD:   o_cmd.op = OP_FIN_RD;
            S_RESULT:   o_cmd.op = OP_RESULT;
            default:    o_cmd.op = OP_IDLE;
        endcase
    end

endmodule

// ===== hdl/dsp_datapath.sv =====
`timescale 1ns / 1ps
module dsp_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dsp_pkg::t_cmd                 i_cmd,
    output dsp_pkg::t_status              o_status,
    input  dsp_pkg::t_in_item             i_in_data,
    input  logic                          i_cfg_valid,
    input  logic [dsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsp_pkg::NODE_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dsp_pkg::t_out_item            o_out_data
);
    import dsp_pkg::*;

    // memories
    logic [EDGE_W-1:0] head_mem [MAX_NODES];
    t_edge_rec         edge_mem [MAX_EDGES];
    logic [DIST_W-1:0] dist_mem [MAX_NODES];
    t_flags            flag_mem [MAX_NODES];
    t_heap_rec         heap_mem [HEAP_DEPTH];

    logic [EDGE_W-1:0] r_head_rd;
    t_edge_rec         r_edge_rd;
    logic [DIST_W-1:0] r_dist_rd;
    t_flags            r_flag_rd;
    t_heap_rec         r_heap_rd;

    // control registers
    logic [NODE_W-1:0] r_src, r_tgt, r_ci;
    logic [EDGE_W-1:0] r_edge_count;
    logic [HIDX_W-1:0] r_heap_size;
    logic              r_out_valid;

    // payload registers
    t_in_item          r_in;
    logic [NODE_W-1:0] r_x, r_to;
    logic [DIST_W-1:0] r_xdist, r_nd;
    logic [EDGE_W-1:0] r_e, r_guard;
    logic [HIDX_W-1:0] r_i, r_c;
    t_heap_rec         r_cv, r_last;
    t_out_item         r_out;

    // combinational
    logic [HIDX_W:0]   w_c_full, w_c1_full;
    logic [HIDX_W-1:0] w_c, w_c1, w_parent, w_heap_raddr, w_heap_waddr;
    logic [DIST_W:0]   w_sum;
    logic [DIST_W-1:0] w_nd;
    logic              w_c2_less, w_room;
    logic [NODE_W-1:0] w_head_raddr, w_node_raddr;
    logic [NODE_W-1:0] w_head_waddr, w_flag_waddr, w_dist_waddr;
    logic [EDGE_W-1:0] w_head_wdata;
    logic              w_head_we, w_edge_we, w_flag_we, w_dist_we, w_heap_we;
    t_flags            w_flag_wdata;
    logic [DIST_W-1:0] w_dist_wdata;
    t_heap_rec         w_heap_wdata, w_new_rec;
    t_edge_rec         w_edge_wdata;
    logic [EIDX_W-1:0] w_edge_raddr;
    t_status           w_st;

    assign w_c_full   = {1'b0, r_i[HIDX_W-2:0], 1'b1} + {r_i[HIDX_W-1], {HIDX_W{1'b0}}};
    assign w_c        = w_c_full[HIDX_W-1:0];
    assign w_c1_full  = {1'b0, r_c} + (HIDX_W+1)'(1);
    assign w_c1       = w_c1_full[HIDX_W-1:0];
    assign w_parent   = (r_i - HIDX_W'(1)) >> 1;
    assign w_sum      = {1'b0, r_xdist} + (DIST_W+1)'(r_edge_rd.weight);
    assign w_nd       = w_sum[DIST_W] ? {DIST_W{1'b1}} : w_sum[DIST_W-1:0];
    assign w_c2_less  = r_heap_rd.cost < r_cv.cost;
    assign w_room     = r_edge_count < EDGE_W'(MAX_EDGES);
    assign w_new_rec  = '{cost: r_nd, node: r_to};
    assign w_edge_raddr = EIDX_W'(r_e - EDGE_W'(1));

    always_comb begin
        w_st.clr_last   = (r_ci == NODE_W'(MAX_NODES - 1));
        w_st.heap_empty = (r_heap_size == '0);
        w_st.pop_single = (r_heap_size == HIDX_W'(1));
        w_st.down_end   = (w_c_full >= {1'b0, r_heap_size});
        w_st.has_c1     = (w_c1_full < {1'b0, r_heap_size});
        w_st.down_stop  = (r_cv.cost >= r_last.cost);
        w_st.visited    = r_flag_rd.visited;
        w_st.edge_more  = (r_e != '0) && (r_e <= r_edge_count) && (r_guard < r_edge_count);
        w_st.relax      = !r_flag_rd.known || (r_dist_rd > r_nd);
        w_st.heap_full  = (r_heap_size == HIDX_W'(HEAP_DEPTH));
        w_st.up_root    = (r_i == '0);
        w_st.up_stop    = (r_heap_rd.cost <= r_nd);
        w_st.out_free   = !r_out_valid || i_out_ready;
    end
    assign o_status = w_st;

    // read addresses
    always_comb begin
        w_head_raddr = (i_cmd.op == OP_VIS_RD) ? r_x : i_in_data.edge_from;
        case (i_cmd.op)
            OP_VIS_RD: w_node_raddr = r_x;
            OP_E_RD:   w_node_raddr = r_edge_rd.to;
            default:   w_node_raddr = r_tgt;
        endcase
        case (i_cmd.op)
            OP_POP_TOP: w_heap_raddr = r_heap_size - HIDX_W'(1);
            OP_POP_CHK: w_heap_raddr = w_c;
            OP_POP_C1:  w_heap_raddr = w_c1;
            OP_PU_CHK:  w_heap_raddr = w_parent;
            default:    w_heap_raddr = '0;
        endcase
    end

    // write ports
    always_comb begin
        w_head_we    = 1'b0;
        w_head_waddr = r_ci;
        w_head_wdata = '0;
        w_edge_we    = 1'b0;
        w_edge_wdata = '{to: r_in.edge_to, next: r_head_rd, weight: r_in.edge_weight};
        w_flag_we    = 1'b0;
        w_flag_waddr = r_ci;
        w_flag_wdata = '0;
        w_dist_we    = 1'b0;
        w_dist_waddr = r_to;
        w_dist_wdata = r_nd;
        w_heap_we    = 1'b0;
        w_heap_waddr = r_i;
        w_heap_wdata = r_last;
        case (i_cmd.op)
            OP_CLR_HEAD: w_head_we = 1'b1;
            OP_ADD: begin
                w_head_we    = w_room;
                w_head_waddr = r_in.edge_from;
                w_head_wdata = r_edge_count + EDGE_W'(1);
                w_edge_we    = w_room;
            end
            OP_RUN_CLR: w_flag_we = 1'b1;
            OP_RUN_INIT: begin
                w_flag_we    = 1'b1;
                w_flag_waddr = r_src;
                w_flag_wdata = '{known: 1'b1, visited: 1'b0};
                w_dist_we    = 1'b1;
                w_dist_waddr = r_src;
                w_dist_wdata = '0;
                w_heap_we    = 1'b1;
                w_heap_waddr = '0;
                w_heap_wdata = '{cost: '0, node: r_src};
            end
            OP_POP_CHK: w_heap_we = w_st.down_end;
            OP_POP_CMP: begin
                w_heap_we    = 1'b1;
                w_heap_wdata = w_st.down_stop ? r_last : r_cv;
            end
            OP_VIS_CHK: begin
                w_flag_we    = !r_flag_rd.visited;
                w_flag_waddr = r_x;
                w_flag_wdata = '{known: 1'b1, visited: 1'b1};
            end
            OP_E_REL: begin
                w_flag_we    = w_st.relax;
                w_flag_waddr = r_to;
                w_flag_wdata = '{known: 1'b1, visited: r_flag_rd.visited};
                w_dist_we    = w_st.relax;
            end
            OP_PU_CHK: begin
                w_heap_we    = w_st.up_root;
                w_heap_wdata = w_new_rec;
            end
            OP_PU_CMP: begin
                w_heap_we    = 1'b1;
                w_heap_wdata = w_st.up_stop ? w_new_rec : r_heap_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) head_mem[w_head_waddr] <= w_head_wdata;
        r_head_rd <= head_mem[w_head_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_edge_we) edge_mem[EIDX_W'(r_edge_count)] <= w_edge_wdata;
        r_edge_rd <= edge_mem[w_edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_flag_we) flag_mem[w_flag_waddr] <= w_flag_wdata;
        r_flag_rd <= flag_mem[w_node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_dist_we) dist_mem[w_dist_waddr] <= w_dist_wdata;
        r_dist_rd <= dist_mem[w_node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_heap_we) heap_mem[w_heap_waddr] <= w_heap_wdata;
        r_heap_rd <= heap_mem[w_heap_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src        <= '0;
            r_tgt        <= NODE_W'(1);
            r_ci         <= '0;
            r_edge_count <= '0;
            r_heap_size  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SOURCE: r_src <= i_cfg_data;
                    CFG_TARGET: r_tgt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_CLR_HEAD || i_cmd.op == OP_RUN_CLR) begin
                r_ci <= r_ci + NODE_W'(1);
            end
            if (i_cmd.op == OP_CLR_HEAD && w_st.clr_last) begin
                r_edge_count <= '0;
            end else if (i_cmd.op == OP_ADD && w_room) begin
                r_edge_count <= r_edge_count + EDGE_W'(1);
            end
            case (i_cmd.op)
                OP_RUN_INIT: r_heap_size <= HIDX_W'(1);
                OP_POP_TOP:  r_heap_size <= r_heap_size - HIDX_W'(1);
                OP_E_REL: begin
                    if (w_st.relax && !w_st.heap_full) begin
                        r_heap_size <= r_heap_size + HIDX_W'(1);
                    end
                end
                default: ;
            endcase
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_in <= i_in_data;
        if (i_cmd.load) begin
            r_out.reached  <= r_flag_rd.known;
            r_out.distance <= r_flag_rd.known ? r_dist_rd : '0;
        end
        case (i_cmd.op)
            OP_POP_TOP: r_x <= r_heap_rd.node;
            OP_POP_LAST: begin
                r_last <= r_heap_rd;
                r_i    <= '0;
            end
            OP_POP_CHK: r_c  <= w_c;
            OP_POP_C1:  r_cv <= r_heap_rd;
            OP_POP_C2: begin
                if (w_c2_less) begin
                    r_cv <= r_heap_rd;
                    r_c  <= w_c1;
                end
            end
            OP_POP_CMP: begin
                if (!w_st.down_stop) r_i <= r_c;
            end
            OP_VIS_CHK: begin
                r_xdist <= r_dist_rd;
                r_e     <= r_head_rd;
                r_guard <= '0;
            end
            OP_E_RD: begin
                r_nd    <= w_nd;
                r_to    <= r_edge_rd.to;
                r_e     <= r_edge_rd.next;
                r_guard <= r_guard + EDGE_W'(1);
            end
            OP_E_REL: r_i <= r_heap_size;
            OP_PU_CMP: begin
                if (!w_st.up_stop) r_i <= w_parent;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/dijkstra_shortest_path.sv =====
`timescale 1ns / 1ps
// Shortest path engine over a loaded directed graph.
// Input channel (valid/ready) carries one request: add edge, run search or clear graph.
// Output channel (valid/ready) carries one result per run request: distance and reached.
// Config channel (valid/ready, always ready) sets source node (index 0) and target node
// (index 1); write it only while no request is in flight.
// Add edge: a read-modify-write of the list head, with input ready low until it is written back.
// Clear graph: one list head cleared per cycle.
// Run: the per-node marks are cleared first, then a data-dependent walk: each heap pop
// sifts down level by level, each edge may push with a sift-up level by level,
// all bound by the single read port of the heap memory.
// After reset the block clears the list heads with input ready low.
// The result waits in an output register; a stalled receiver delays only the next run's
// completion, and add or clear requests are still accepted meanwhile.
module dijkstra_shortest_path (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dsp_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dsp_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsp_pkg::NODE_W-1:0]    i_cfg_data
);
    import dsp_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    dsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_in_data.action),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dsp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
